// File: hdl/mio0lz_pkg.sv
// ----------------------------------------------------------------------------
// mio0lz_pkg
// Shared types, codes and helpers of the MIO0 LZ decompressor.
// ----------------------------------------------------------------------------
package mio0lz_pkg;

  localparam int HISTORY_DEPTH_DEF = 4096;
  localparam int SIZE_BITS_DEF     = 24;

  localparam int POS_W     = 24;
  localparam int FLAG_W    = 32;
  localparam int FLAGS_W   = 6;
  localparam int LEN_W     = 5;
  localparam int DIST_W    = 12;
  localparam int LEN_BIAS  = 3;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_FLAG    = 2'd1;
  localparam logic [1:0] CMD_LITERAL = 2'd2;
  localparam logic [1:0] CMD_PAIR    = 2'd3;

  localparam logic [1:0] KIND_FLAG    = 2'd0;
  localparam logic [1:0] KIND_LITERAL = 2'd1;
  localparam logic [1:0] KIND_PAIR    = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             byte_valid;
    logic [POS_W-1:0] byte_position;
    logic             run_last;
    logic [1:0]       next_kind;
    logic             finished;
    logic             fault;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic             ignore;
    logic             set_fault;
    logic             flag;
    logic             literal;
    logic             pair;
    logic [LEN_W-1:0] len;
    logic [DIST_W:0]  back;
  } chk_t;

  function automatic logic [1:0] kind_of(input logic fault, input logic fin,
                                         input logic [FLAGS_W-1:0] left,
                                         input logic msb);
    logic [1:0] k;
    if (fault || fin) begin
      k = KIND_NONE;
    end else if (left == '0) begin
      k = KIND_FLAG;
    end else if (msb) begin
      k = KIND_LITERAL;
    end else begin
      k = KIND_PAIR;
    end
    return k;
  endfunction

endpackage

// File: hdl/mio0lz_item_check.sv
// ----------------------------------------------------------------------------
// mio0lz_item_check
// Classifies an incoming word against the decoder state and unpacks pairs.
// ----------------------------------------------------------------------------
module mio0lz_item_check import mio0lz_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  in_word_t               item,
  input  logic                   fault,
  input  logic                   fin,
  input  logic [FLAGS_W-1:0]     flags_left,
  input  logic                   flag_msb,
  input  logic [SIZE_BITS-1:0]   produced,
  output chk_t                   chk
);

  logic [1:0] kind;
  logic       kind_ok;

  always_comb begin
    kind    = kind_of(fault, fin, flags_left, flag_msb);
    kind_ok = (item.command == CMD_FLAG    && kind == KIND_FLAG)    ||
              (item.command == CMD_LITERAL && kind == KIND_LITERAL) ||
              (item.command == CMD_PAIR    && kind == KIND_PAIR);

    chk.len  = LEN_W'(item.value[15:12]) + LEN_W'(LEN_BIAS);
    chk.back = {1'b0, item.value[DIST_W-1:0]} + (DIST_W+1)'(1);

    chk.start     = 1'b0;
    chk.ignore    = 1'b0;
    chk.set_fault = 1'b0;
    chk.flag      = 1'b0;
    chk.literal   = 1'b0;
    chk.pair      = 1'b0;

    priority if (item.command == CMD_START) begin
      chk.start = 1'b1;
    end else if (fault) begin
      chk.ignore = 1'b1;
    end else if (fin || !kind_ok) begin
      chk.set_fault = 1'b1;
    end else if (item.command == CMD_FLAG) begin
      chk.flag = 1'b1;
    end else if (item.command == CMD_LITERAL) begin
      chk.literal = 1'b1;
    end else if (SIZE_BITS'(chk.back) > produced) begin
      chk.set_fault = 1'b1;
    end else begin
      chk.pair = 1'b1;
    end
  end

endmodule

// File: hdl/mio0_lz_decompressor.sv
// ----------------------------------------------------------------------------
// mio0_lz_decompressor
// MIO0 LZ decompressor core with a byte history RAM.
// ----------------------------------------------------------------------------
// The feeder writes cfg_wr_data (segment size) while idle, sends a start
// word, then flag words, literals and back-reference pairs on the in_
// channel. Every word gives one or more result words on the out_ channel.
// Start, flag, literal, faulting and ignored words load their result into the
// output register on acceptance; it sits there on the following cycle.
// A pair enters the copy state: each byte is read from the history RAM into
// a read register, then loaded into the output register, one byte per cycle
// unless out_ stalls (runs reading the byte just written are forwarded).
// No new word is taken while a pair run is in progress.
// A stall on out_ holds the output register and freezes the run; a word
// whose result cannot be loaded is held off with in_stall.
// Reset clears the size register, the flag and count state and the fault;
// the history RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module mio0_lz_decompressor import mio0lz_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int SIZE_BITS     = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [SIZE_BITS-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_COPY = 1'b1;

  logic                 state_r, state_nxt;
  logic [SIZE_BITS-1:0] total_size_r;
  logic [FLAG_W-1:0]    flag_word_r, flag_word_nxt;
  logic [FLAGS_W-1:0]   flags_left_r, flags_left_nxt;
  logic [SIZE_BITS-1:0] produced_r, produced_nxt;
  logic                 fault_r, fault_nxt;
  logic [AW-1:0]        src_r, src_nxt;
  logic [LEN_W-1:0]     left_r, left_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  logic [7:0]           hist_mem [HISTORY_DEPTH];
  logic [7:0]           mem_q_r;
  logic                 fwd_r;
  logic [7:0]           fwd_data_r;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [7:0]           wdata;
  logic [AW-1:0]        raddr;

  logic                 in_acc, can_emit, load_out;
  logic [7:0]           ob_byte;
  logic                 ob_valid, ob_last;
  logic [SIZE_BITS-1:0] ob_pos;
  logic                 fin_cur;
  chk_t                 chk;

  assign fin_cur  = produced_r >= total_size_r;
  assign can_emit = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !can_emit;
  assign in_acc   = in_valid && !in_stall;

  mio0lz_item_check #(
    .SIZE_BITS (SIZE_BITS)
  ) u_check (
    .item       (in_word),
    .fault      (fault_r),
    .fin        (fin_cur),
    .flags_left (flags_left_r),
    .flag_msb   (flag_word_r[FLAG_W-1]),
    .produced   (produced_r),
    .chk        (chk)
  );

  always_comb begin
    state_nxt      = state_r;
    flag_word_nxt  = flag_word_r;
    flags_left_nxt = flags_left_r;
    produced_nxt   = produced_r;
    fault_nxt      = fault_r;
    src_nxt        = src_r;
    left_nxt       = left_r;
    we             = 1'b0;
    waddr          = produced_r[AW-1:0];
    wdata          = 8'd0;
    load_out       = 1'b0;
    ob_byte        = 8'd0;
    ob_valid       = 1'b0;
    ob_last        = 1'b1;
    ob_pos         = produced_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (chk.start) begin
            flag_word_nxt  = '0;
            flags_left_nxt = '0;
            produced_nxt   = '0;
            fault_nxt      = 1'b0;
            load_out       = 1'b1;
            ob_pos         = '0;
          end else if (chk.ignore) begin
            load_out = 1'b1;
          end else if (chk.set_fault) begin
            fault_nxt = 1'b1;
            load_out  = 1'b1;
          end else if (chk.flag) begin
            flag_word_nxt  = in_word.value;
            flags_left_nxt = FLAGS_W'(FLAG_W);
            load_out       = 1'b1;
          end else if (chk.literal) begin
            flag_word_nxt  = flag_word_r << 1;
            flags_left_nxt = flags_left_r - FLAGS_W'(1);
            we             = 1'b1;
            wdata          = in_word.value[7:0];
            produced_nxt   = produced_r + SIZE_BITS'(1);
            load_out       = 1'b1;
            ob_byte        = in_word.value[7:0];
            ob_valid       = 1'b1;
          end else begin
            flag_word_nxt  = flag_word_r << 1;
            flags_left_nxt = flags_left_r - FLAGS_W'(1);
            src_nxt        = produced_r[AW-1:0] - AW'(chk.back);
            left_nxt       = chk.len;
            state_nxt      = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        if (can_emit) begin
          ob_byte      = fwd_r ? fwd_data_r : mem_q_r;
          we           = 1'b1;
          wdata        = ob_byte;
          produced_nxt = produced_r + SIZE_BITS'(1);
          src_nxt      = src_r + AW'(1);
          left_nxt     = left_r - LEN_W'(1);
          load_out     = 1'b1;
          ob_valid     = 1'b1;
          ob_last      = (left_r == LEN_W'(1)) || (produced_nxt >= total_size_r);
          if (ob_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    raddr = src_nxt;

    out_valid_nxt = (out_valid_r && out_stall) || load_out;
    out_word_nxt  = out_word_r;
    if (load_out) begin
      out_word_nxt.data_byte     = ob_byte;
      out_word_nxt.byte_valid    = ob_valid;
      out_word_nxt.byte_position = POS_W'(ob_pos);
      out_word_nxt.run_last      = ob_last;
      out_word_nxt.finished      = produced_nxt >= total_size_r;
      out_word_nxt.fault         = fault_nxt;
      out_word_nxt.next_kind     = kind_of(fault_nxt, produced_nxt >= total_size_r,
                                           flags_left_nxt, flag_word_nxt[FLAG_W-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      total_size_r <= '0;
      flag_word_r  <= '0;
      flags_left_r <= '0;
      produced_r   <= '0;
      fault_r      <= 1'b0;
      left_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flag_word_r  <= flag_word_nxt;
      flags_left_r <= flags_left_nxt;
      produced_r   <= produced_nxt;
      fault_r      <= fault_nxt;
      left_r       <= left_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        total_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    out_word_r <= out_word_nxt;
  end

  // history ram with same-cycle write forwarding
  always_ff @(posedge clk) begin
    if (we) begin
      hist_mem[waddr] <= wdata;
    end
    mem_q_r    <= hist_mem[raddr];
    fwd_r      <= we && (raddr == waddr);
    fwd_data_r <= wdata;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: dv/mio0_lz_decompressor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mio0_lz_decompressor_tb
// Self-checking bench for the MIO0 LZ decompressor. Directed words hit the
// size extremes, run cut-off, bad distance, wrong kind and words after finish;
// random well-formed segments with some noise follow. A scoreboard predicts
// every result word and compares it field by field while both channels idle
// at random and the receiver once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module mio0_lz_decompressor_tb;
  import mio0lz_pkg::*;

  localparam int HIST_DEPTH = 4096;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_LINES = 40;

  class mio0_scoreboard;
    logic [POS_W-1:0]   size_lim;
    logic [FLAG_W-1:0]  flag_bits;
    logic [FLAGS_W-1:0] flags_left;
    logic [POS_W-1:0]   made;
    logic               faulted;
    logic [7:0]         hist [HIST_DEPTH];
    out_word_t          expected_out [$];
    int                 errors;

    function new();
      size_lim   = '0;
      flag_bits  = '0;
      flags_left = '0;
      made       = '0;
      faulted    = 1'b0;
      errors     = 0;
    endfunction

    function void set_size(logic [POS_W-1:0] v);
      size_lim = v;
    endfunction

    function logic done();
      return made >= size_lim;
    endfunction

    function logic [1:0] next_kind();
      logic [1:0] k;
      if (faulted || done()) begin
        k = KIND_NONE;
      end else if (flags_left == '0) begin
        k = KIND_FLAG;
      end else if (flag_bits[FLAG_W-1]) begin
        k = KIND_LITERAL;
      end else begin
        k = KIND_PAIR;
      end
      return k;
    endfunction

    function out_word_t status(logic [7:0] b, logic v, logic [POS_W-1:0] pos, logic last);
      out_word_t o;
      o.data_byte     = b;
      o.byte_valid    = v;
      o.byte_position = pos;
      o.run_last      = last;
      o.next_kind     = next_kind();
      o.finished      = done();
      o.fault         = faulted;
      return o;
    endfunction

    function void take_flag();
      flag_bits = flag_bits << 1;
      if (flags_left != '0) begin
        flags_left = flags_left - FLAGS_W'(1);
      end
    endfunction

    function void put_byte(logic [7:0] b);
      hist[made % HIST_DEPTH] = b;
      made = made + POS_W'(1);
    endfunction

    function void note_word(in_word_t w);
      logic [1:0]       want;
      logic [LEN_W-1:0] run_len;
      logic [DIST_W:0]  back;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] src;
      logic [7:0]       b;
      out_word_t        held;
      int               i;
      want = KIND_NONE;
      case (w.command)
        CMD_FLAG:    want = KIND_FLAG;
        CMD_LITERAL: want = KIND_LITERAL;
        CMD_PAIR:    want = KIND_PAIR;
        default:     want = KIND_NONE;
      endcase
      if (w.command == CMD_START) begin
        flag_bits  = '0;
        flags_left = '0;
        made       = '0;
        faulted    = 1'b0;
        expected_out.push_back(status(8'h00, 1'b0, made, 1'b1));
        return;
      end
      if (faulted) begin
        expected_out.push_back(status(8'h00, 1'b0, made, 1'b1));
        return;
      end
      if (done() || next_kind() != want) begin
        faulted = 1'b1;
        expected_out.push_back(status(8'h00, 1'b0, made, 1'b1));
        return;
      end
      case (w.command)
        CMD_FLAG: begin
          flag_bits  = w.value;
          flags_left = FLAGS_W'(FLAG_W);
          expected_out.push_back(status(8'h00, 1'b0, made, 1'b1));
        end
        CMD_LITERAL: begin
          pos = made;
          b   = w.value[7:0];
          take_flag();
          put_byte(b);
          expected_out.push_back(status(b, 1'b1, pos, 1'b1));
        end
        default: begin
          run_len = LEN_W'(w.value[15:12]) + LEN_W'(LEN_BIAS);
          back    = {1'b0, w.value[DIST_W-1:0]} + (DIST_W+1)'(1);
          if (back > made) begin
            faulted = 1'b1;
            expected_out.push_back(status(8'h00, 1'b0, made, 1'b1));
            return;
          end
          take_flag();
          i = 0;
          while (i < run_len && made < size_lim) begin
            pos = made;
            src = pos - back;
            b   = hist[src % HIST_DEPTH];
            put_byte(b);
            if (i > 0) begin
              expected_out.push_back(held);
            end
            held = status(b, 1'b1, pos, 1'b0);
            i++;
          end
          held.run_last = 1'b1;
          expected_out.push_back(held);
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_LINES) begin
        $display("ERROR @%0t: %s", $realtime, msg);
      end
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      string     bad;
      if (expected_out.size() == 0) begin
        report($sformatf("result word with nothing expected: %h", got));
        return;
      end
      want = expected_out.pop_front();
      bad  = "";
      if (got.data_byte !== want.data_byte) bad = {bad, " data_byte"};
      if (got.byte_valid !== want.byte_valid) bad = {bad, " byte_valid"};
      if (got.byte_position !== want.byte_position) bad = {bad, " byte_position"};
      if (got.run_last !== want.run_last) bad = {bad, " run_last"};
      if (got.next_kind !== want.next_kind) bad = {bad, " next_kind"};
      if (got.finished !== want.finished) bad = {bad, " finished"};
      if (got.fault !== want.fault) bad = {bad, " fault"};
      if (bad != "") begin
        report($sformatf("mismatch in%s: exp %h got %h", bad, want, got));
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [POS_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  in_word_t         in_word;
  logic             out_valid;
  logic             out_stall;
  out_word_t        out_word;

  mio0_scoreboard sb;
  int             gap_pct;
  int             stall_pct;
  bit             hold_req;
  int             cycles;

  mio0_lz_decompressor u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // receiver: checks accepted words and stalls in bursts
  initial begin : rx
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_valid === 1'b1 && out_stall === 1'b0) begin
          sb.check_word(out_word);
        end
        if (hold_left > 0) begin
          hold_left--;
        end else if (hold_req) begin
          hold_req  = 1'b0;
          hold_left = 300;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
          hold_left = $urandom_range(1, 11);
        end
        out_stall <= (hold_left > 0);
      end
    end
  end

  task send_word(logic [1:0] cmd, logic [31:0] val);
    in_word_t w;
    w.command = cmd;
    w.value   = val;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_word(w);
  endtask

  task settle();
    in_valid <= 1'b0;
    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_size(logic [POS_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_size(v);
  endtask

  function logic [POS_W-1:0] pick_size();
    logic [POS_W-1:0] v;
    case ($urandom_range(0, 15))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = POS_W'($urandom_range(300, 1500));
      default: v = POS_W'($urandom_range(1, 80));
    endcase
    return v;
  endfunction

  // mostly well-formed segments, with a share of random words
  task run_stream(int count, int noise_pct);
    logic [1:0]  cmd;
    logic [31:0] val;
    int          lim;
    int          k;
    for (k = 0; k < count; k++) begin
      val = $urandom;
      if ($urandom_range(0, 99) < noise_pct) begin
        cmd = 2'($urandom_range(0, 3));
      end else begin
        case (sb.next_kind())
          KIND_FLAG:    cmd = CMD_FLAG;
          KIND_LITERAL: cmd = CMD_LITERAL;
          KIND_PAIR: begin
            cmd = CMD_PAIR;
            if (sb.made != 0) begin
              lim = (sb.made > HIST_DEPTH) ? HIST_DEPTH - 1 : sb.made - 1;
              if ($urandom_range(0, 1) == 1) begin
                lim = (lim > 3) ? 3 : lim;
              end
              val[DIST_W-1:0] = DIST_W'($urandom_range(0, lim));
            end
          end
          default: begin
            if ($urandom_range(0, 3) == 0) begin
              settle();
              write_size(pick_size());
            end
            cmd = CMD_START;
          end
        endcase
      end
      send_word(cmd, val);
    end
  endtask

  initial begin
    sb          = new();
    gap_pct     = 20;
    stall_pct   = 20;
    hold_req    = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_word     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size still zero from reset
    send_word(CMD_LITERAL, 32'hFFFF_FF00);
    send_word(CMD_FLAG, 32'hFFFF_FFFF);
    send_word(CMD_START, 32'h0000_0000);
    send_word(CMD_PAIR, 32'h0000_FFFF);
    settle();
    write_size(24'd12);
    send_word(CMD_START, 32'hFFFF_FFFF);
    send_word(CMD_PAIR, 32'h0000_0000);
    send_word(CMD_START, 32'h0000_0000);
    send_word(CMD_FLAG, 32'hC800_0000);
    send_word(CMD_LITERAL, 32'hFFFF_FF00);
    send_word(CMD_LITERAL, 32'h0000_00FF);
    // longest run, cut at the segment size
    send_word(CMD_PAIR, 32'h0000_F000);
    send_word(CMD_LITERAL, 32'h0000_0012);
    send_word(CMD_START, 32'h0000_0000);
    send_word(CMD_FLAG, 32'h4000_0000);
    send_word(CMD_PAIR, 32'h0000_0000);
    send_word(CMD_LITERAL, 32'h0000_0034);
    settle();
    write_size(24'hFF_FFFF);
    send_word(CMD_START, 32'h0000_0000);
    send_word(CMD_FLAG, 32'h8000_0000);
    send_word(CMD_LITERAL, 32'h0000_005A);
    send_word(CMD_PAIR, 32'h0000_0001);
    send_word(CMD_START, 32'h0000_0000);
    send_word(CMD_FLAG, 32'hA000_0000);
    send_word(CMD_LITERAL, 32'h0000_00A5);
    send_word(CMD_PAIR, 32'hFFFF_0000);
    send_word(CMD_LITERAL, 32'h0000_003C);
    send_word(CMD_PAIR, 32'h0000_0FFF);
    settle();
    write_size(POS_W'($urandom_range(16, 400)));

    // long receiver hold-off while words keep coming
    hold_req  = 1'b1;
    gap_pct   = 30;
    stall_pct = 30;
    run_stream(45, 8);
    gap_pct   = 50;
    stall_pct = 10;
    run_stream(30, 10);
    gap_pct   = 0;
    stall_pct = 0;
    run_stream(20, 5);

    in_valid <= 1'b0;
    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_out.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
